// ===== design/lr_pkg.sv =====
// Shared types and constants for the line rasteriser.
// No dependencies; imported by lr_setup, lr_walker and line_rasterizer.
package lr_pkg;

  // Field widths that do not vary with the coordinate size.
  localparam int COLOR_BITS = 16;
  localparam int ADDR_BITS  = 32;

  // Input word kind, carried on in_tuser.
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_t;

  // Control from the top level to the walker.
  typedef struct packed {
    logic start;   // load a new line from the setup logic
    logic advance; // step one pixel along the current line
  } walk_ctrl_t;

endpackage

// ===== design/lr_setup.sv =====
// Line setup: works out axis swap, endpoint order, deltas and initial error.
// Purely combinational; depends on lr_pkg.
module lr_setup #(
  parameter int CB = 10
) (
  input  logic [CB-1:0]   x_start,
  input  logic [CB-1:0]   y_start,
  input  logic [CB-1:0]   x_end,
  input  logic [CB-1:0]   y_end,
  output logic            steep,
  output logic [CB-1:0]   major_start,
  output logic [CB-1:0]   minor_start,
  output logic [CB-1:0]   major_stop,
  output logic [CB-1:0]   major_delta,
  output logic [CB-1:0]   minor_delta,
  output logic            minor_down,
  output logic [CB+1:0]   err_init
);
  import lr_pkg::*;

  logic [CB-1:0] dx, dy;
  logic [CB-1:0] a_maj, a_min, b_maj, b_min;
  logic [CB-1:0] minor_stop;
  logic          swap;

  // Absolute deltas decide whether the line is steep.
  assign dx    = (x_start > x_end) ? (x_start - x_end) : (x_end - x_start);
  assign dy    = (y_start > y_end) ? (y_start - y_end) : (y_end - y_start);
  assign steep = dy > dx;

  // Map onto major and minor axes.
  assign a_maj = steep ? y_start : x_start;
  assign a_min = steep ? x_start : y_start;
  assign b_maj = steep ? y_end   : x_end;
  assign b_min = steep ? x_end   : y_end;

  // Order the endpoints so that the major coordinate runs upward.
  assign swap        = a_maj > b_maj;
  assign major_start = swap ? b_maj : a_maj;
  assign minor_start = swap ? b_min : a_min;
  assign major_stop  = swap ? a_maj : b_maj;
  assign minor_stop  = swap ? a_min : b_min;

  assign major_delta = major_stop - major_start;
  assign minor_delta = (minor_stop > minor_start) ? (minor_stop - minor_start)
                                                  : (minor_start - minor_stop);
  assign minor_down  = minor_stop < minor_start;

  // Error starts at minus half the major delta.
  assign err_init = (CB+2)'(0) - (CB+2)'(major_delta >> 1);

endmodule

// ===== design/lr_walker.sv =====
// Bresenham walker: holds the line state and steps one pixel per advance.
// Depends on lr_pkg for the control struct and colour width.
module lr_walker #(
  parameter int CB = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lr_pkg::walk_ctrl_t            ctrl,
  input  logic                          ld_steep,
  input  logic [CB-1:0]                 ld_major_start,
  input  logic [CB-1:0]                 ld_minor_start,
  input  logic [CB-1:0]                 ld_major_stop,
  input  logic [CB-1:0]                 ld_major_delta,
  input  logic [CB-1:0]                 ld_minor_delta,
  input  logic                          ld_minor_down,
  input  logic [CB+1:0]                 ld_err_init,
  input  logic [lr_pkg::COLOR_BITS-1:0] ld_color,
  output logic                          busy,
  output logic [CB-1:0]                 pix_x,
  output logic [CB-1:0]                 pix_y,
  output logic                          pix_last,
  output logic [lr_pkg::COLOR_BITS-1:0] pix_color
);
  import lr_pkg::*;

  localparam int EB = CB + 2;

  logic                  busy_r, busy_nxt;
  logic                  steep_r;
  logic [CB-1:0]         major_r, major_nxt;
  logic [CB-1:0]         minor_r, minor_nxt;
  logic [CB-1:0]         stop_r;
  logic [CB-1:0]         maj_delta_r;
  logic [CB-1:0]         min_delta_r;
  logic                  down_r;
  logic [EB-1:0]         err_r, err_nxt;
  logic [COLOR_BITS-1:0] color_r;

  logic signed [EB:0]    err_sum;
  logic signed [EB:0]    err_adj;
  logic                  fin;

  // Current pixel, mapped back from major and minor axes.
  assign fin       = major_r == stop_r;
  assign pix_x     = steep_r ? minor_r : major_r;
  assign pix_y     = steep_r ? major_r : minor_r;
  assign pix_last  = fin;
  assign pix_color = color_r;
  assign busy      = busy_r;

  // Error update, kept one bit wider than the register so the sign is exact.
  assign err_sum = $signed({err_r[EB-1], err_r}) + $signed({3'b000, min_delta_r});
  assign err_adj = err_sum - $signed({3'b000, maj_delta_r});

  // Next state of the stepping registers.
  always_comb begin
    busy_nxt  = busy_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    err_nxt   = err_r;
    if (ctrl.start) begin
      busy_nxt  = 1'b1;
      major_nxt = ld_major_start;
      minor_nxt = ld_minor_start;
      err_nxt   = ld_err_init;
    end else if (ctrl.advance) begin
      if (fin) begin
        busy_nxt = 1'b0;
      end else begin
        major_nxt = major_r + CB'(1);
        if (!err_sum[EB]) begin
          minor_nxt = down_r ? (minor_r - CB'(1)) : (minor_r + CB'(1));
          err_nxt   = err_adj[EB-1:0];
        end else begin
          err_nxt   = err_sum[EB-1:0];
        end
      end
    end
  end

  // Busy flag is the only control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Line state.
  always_ff @(posedge clk) begin
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    err_r   <= err_nxt;
    if (ctrl.start) begin
      steep_r     <= ld_steep;
      stop_r      <= ld_major_stop;
      maj_delta_r <= ld_major_delta;
      min_delta_r <= ld_minor_delta;
      down_r      <= ld_minor_down;
      color_r     <= ld_color;
    end
  end

endmodule

// ===== design/line_rasterizer.sv =====
// Top level of the Bresenham line rasteriser with frame-buffer addressing.
// Depends on lr_pkg, lr_setup and lr_walker.

// A start word (in_tuser = 0) loads a new line and gives no pixel; each tick
// word (in_tuser = 1) gives the next pixel of the line, both endpoints drawn,
// the final one marked by out_tlast, and ticks with no line in progress are
// dropped. While out_tready is not holding it back, the block takes one word per
// clock and gives one pixel per clock: a word is held in the input register, the
// setup or the error step runs combinationally while it sits there, and the
// pixel is loaded into the output register as the word leaves and held until
// out_tready takes it. in_tready follows out_tready combinationally when both
// registers are full. Byte address is
// frame_base + (y << ROW_SHIFT) + 2 * x, modulo 2^32. frame_base should be
// written only while the block is idle.
module line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int ROW_SHIFT  = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration: frame_base.
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data,
  // Input words.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata, from bit 0: x_start, y_start, x_end, y_end, color_in, zero padding
  input  logic [((4*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0] in_tdata,
  // tuser: func
  input  logic                   in_tuser,
  // Pixel words.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata, from bit 0: pixel_x, pixel_y, pixel_addr, pixel_color, zero padding
  output logic [((2*COORD_BITS+lr_pkg::ADDR_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0] out_tdata,
  output logic                   out_tlast
);
  import lr_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int IN_W  = ((4*CB + COLOR_BITS + 7) / 8) * 8;
  localparam int OUT_P = 2*CB + ADDR_BITS + COLOR_BITS;
  localparam int OUT_W = ((OUT_P + 7) / 8) * 8;

  // Configuration register.
  logic [ADDR_BITS-1:0] frame_base_r;

  // Input register.
  logic            s1_valid_r, s1_valid_nxt;
  func_t           s1_func_r;
  logic [IN_W-1:0] s1_data_r;
  logic            s1_fire;
  logic            in_fire;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;
  logic             out_last_r;

  // Setup results.
  logic          su_steep, su_down;
  logic [CB-1:0] su_maj_start, su_min_start, su_maj_stop, su_maj_delta, su_min_delta;
  logic [CB+1:0] su_err;

  // Walker interface.
  walk_ctrl_t            wctrl;
  logic                  w_busy, w_last;
  logic [CB-1:0]         w_x, w_y;
  logic [COLOR_BITS-1:0] w_color;
  logic                  emit;
  logic [ADDR_BITS-1:0]  pix_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
    end else if (cfg_wr_en) begin
      frame_base_r <= cfg_wr_data;
    end
  end

  // Handshake: the input register moves on when the output register has room.
  assign s1_fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || s1_fire;
  assign in_fire      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= func_t'(in_tuser);
      s1_data_r <= in_tdata;
    end
  end

  lr_setup #(.CB(CB)) u_setup (
    .x_start     (s1_data_r[CB-1:0]),
    .y_start     (s1_data_r[2*CB-1:CB]),
    .x_end       (s1_data_r[3*CB-1:2*CB]),
    .y_end       (s1_data_r[4*CB-1:3*CB]),
    .steep       (su_steep),
    .major_start (su_maj_start),
    .minor_start (su_min_start),
    .major_stop  (su_maj_stop),
    .major_delta (su_maj_delta),
    .minor_delta (su_min_delta),
    .minor_down  (su_down),
    .err_init    (su_err)
  );

  // A tick emits a pixel only while a line is in progress.
  assign emit = s1_fire && (s1_func_r == FUNC_TICK) && w_busy;

  always_comb begin
    wctrl.start   = s1_fire && (s1_func_r == FUNC_START);
    wctrl.advance = emit;
  end

  lr_walker #(.CB(CB)) u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (wctrl),
    .ld_steep       (su_steep),
    .ld_major_start (su_maj_start),
    .ld_minor_start (su_min_start),
    .ld_major_stop  (su_maj_stop),
    .ld_major_delta (su_maj_delta),
    .ld_minor_delta (su_min_delta),
    .ld_minor_down  (su_down),
    .ld_err_init    (su_err),
    .ld_color       (s1_data_r[4*CB+COLOR_BITS-1:4*CB]),
    .busy           (w_busy),
    .pix_x          (w_x),
    .pix_y          (w_y),
    .pix_last       (w_last),
    .pix_color      (w_color)
  );

  // Frame-buffer byte address, wrapping at 32 bits.
  assign pix_addr = frame_base_r + (ADDR_BITS'(w_y) << ROW_SHIFT)
                  + (ADDR_BITS'(w_x) << 1);

  // Output register.
  always_comb begin
    if (s1_fire) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= OUT_W'({w_color, pix_addr, w_y, w_x});
      out_last_r <= w_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A new pixel only ever appears after a tick went through.
  a_pixel_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_func_r == FUNC_TICK))
    else $error("pixel appeared without a tick");

  // A start word never produces a pixel.
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_func_r == FUNC_START) |=> !out_valid_r)
    else $error("start word produced a pixel");

  // Emitting the final endpoint ends the line.
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && w_last) |=> !w_busy)
    else $error("line still busy after its last pixel");

endmodule
